// ----- sv/teb_pkg.sv -----
// shared types and constants for the timestamp event builder
// no dependencies; imported by every module of the block
package teb_pkg;

  // default channel count per digitizer module
  localparam int CHANNELS_PER_MODULE_DEF = 16;

  // field widths
  localparam int MOD_W    = 4;
  localparam int CH_W     = 4;
  localparam int ENERGY_W = 16;
  localparam int LTIME_W  = 40;
  localparam int GROUP_W  = 16;
  localparam int FULL_W   = 56;
  localparam int GID_W    = 8;
  localparam int MULT_W   = 8;
  localparam int COUNT_W  = 32;

  // hit queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // highest module number of the low valid range, and the offset of the high range
  localparam logic [MOD_W-1:0] MOD_LOW_LAST   = 4'd2;
  localparam logic [MOD_W-1:0] MOD_HIGH_FIRST = 4'd9;
  localparam logic [MOD_W-1:0] MOD_HIGH_SHIFT = 4'd6;

  // saturation value of the hit count
  localparam logic [MULT_W-1:0] MULT_MAX = 8'd255;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENERGY_THRESHOLD   = 2'd0,
    CFG_SKIP_TIME_ERRORS   = 2'd1,
    CFG_STOP_ON_TIME_ERROR = 2'd2,
    CFG_EVENT_LIMIT        = 2'd3
  } cfg_index_t;

  // input word kinds
  localparam logic KIND_HIT   = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // result word kinds
  localparam logic REC_HIT = 1'b0;
  localparam logic REC_END = 1'b1;

  // configuration register set
  typedef struct packed {
    logic [ENERGY_W-1:0] energy_threshold;
    logic                skip_time_errors;
    logic                stop_on_time_error;
    logic [COUNT_W-1:0]  event_limit;
  } cfg_t;

  // classified word as it travels through the queue
  typedef struct packed {
    logic                kind;
    logic [MOD_W-1:0]    module_req;
    logic [CH_W-1:0]     channel;
    logic [ENERGY_W-1:0] energy;
    logic [LTIME_W-1:0]  local_time;
    logic [GROUP_W-1:0]  time_group;
    logic [FULL_W-1:0]   full;
    logic [GID_W-1:0]    gid;
  } hit_t;

  // one result word
  typedef struct packed {
    logic                record_type;
    logic [MOD_W-1:0]    module_out;
    logic [CH_W-1:0]     channel_out;
    logic [GID_W-1:0]    global_id;
    logic [ENERGY_W-1:0] energy_out;
    logic [LTIME_W-1:0]  local_time_out;
    logic [GROUP_W-1:0]  group_out;
    logic [FULL_W-1:0]   full_time;
    logic [MULT_W-1:0]   multiplicity;
    logic [COUNT_W-1:0]  event_number;
    logic [COUNT_W-1:0]  time_error_count;
    logic                last;
  } result_t;

endpackage

// ----- sv/teb_front.sv -----
// front part: accepts input words, drops unused hits, builds the extended time
// and the global channel id; depends on teb_pkg
module teb_front import teb_pkg::*; #(
  parameter int CHANNELS_PER_MODULE = CHANNELS_PER_MODULE_DEF
) (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [MOD_W-1:0]    module_req,
  input  logic [CH_W-1:0]     channel,
  input  logic [ENERGY_W-1:0] energy,
  input  logic [LTIME_W-1:0]  local_time,
  input  logic [GROUP_W-1:0]  time_group,
  input  cfg_t                cfg,
  input  logic                q_full,
  output logic                q_wr,
  output hit_t                q_data
);

  localparam int PROD_W = MOD_W + $clog2(CHANNELS_PER_MODULE + 1) + 1;

  logic              bad_module;
  logic              low_energy;
  logic [MOD_W-1:0]  mod_index;
  logic [PROD_W-1:0] gid_wide;

  // hits from the unused modules or under threshold never reach the back
  assign bad_module = (module_req > MOD_LOW_LAST) && (module_req < MOD_HIGH_FIRST);
  assign low_energy = energy < cfg.energy_threshold;

  // module index with the gap of unused modules removed
  assign mod_index = (module_req > MOD_LOW_LAST) ? (module_req - MOD_HIGH_SHIFT) : module_req;
  assign gid_wide  = PROD_W'(mod_index) * PROD_W'(CHANNELS_PER_MODULE) + PROD_W'(channel);

  assign in_stall = q_full;

  // classified word into the queue
  always_comb begin
    q_data.kind       = kind;
    q_data.module_req = module_req;
    q_data.channel    = channel;
    q_data.energy     = energy;
    q_data.local_time = local_time;
    q_data.time_group = time_group;
    // full = local + group * (2^40 - 1)
    q_data.full       = {time_group, {LTIME_W{1'b0}}} - FULL_W'(time_group)
                        + FULL_W'(local_time);
    q_data.gid        = gid_wide[GID_W-1:0];
    q_wr = in_valid && !q_full &&
           ((kind == KIND_FLUSH) || (!bad_module && !low_energy));
  end

endmodule

// ----- sv/teb_queue.sv -----
// short first-in first-out queue of classified words between front and back
// depends on teb_pkg
module teb_queue import teb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  hit_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output hit_t rd_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hit_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- sv/teb_back.sv -----
// back part: event building state, result words and the output register
// depends on teb_pkg
module teb_back import teb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  hit_t    q_data,
  output logic    q_rd,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_word
);

  // event state
  logic [FULL_W-1:0]  previous_time;
  logic               have_previous;
  logic [FULL_W-1:0]  lowest_decreased_time;
  logic [MULT_W-1:0]  hits_in_event;
  logic               event_open;
  logic [COUNT_W-1:0] events_started;
  logic [COUNT_W-1:0] error_total;
  logic               limit_reached;
  logic               halted;

  logic [FULL_W-1:0]  previous_time_next;
  logic               have_previous_next;
  logic [FULL_W-1:0]  lowest_decreased_time_next;
  logic [MULT_W-1:0]  hits_in_event_next;
  logic               event_open_next;
  logic [COUNT_W-1:0] events_started_next;
  logic [COUNT_W-1:0] error_total_next;
  logic               limit_reached_next;
  logic               halted_next;

  // second word of a two word result
  logic    pend_valid;
  result_t pend_word;

  logic       out_free;
  logic       take;
  logic [1:0] n_words;
  result_t    word0;
  result_t    word1;
  logic       earlier;
  logic       joins;
  logic       check_limit;

  function automatic result_t end_word(logic [FULL_W-1:0] t, logic [MULT_W-1:0] hits,
                                       logic [COUNT_W-1:0] ev, logic [COUNT_W-1:0] err,
                                       logic lst);
    result_t r;
    r                  = '0;
    r.record_type      = REC_END;
    r.full_time        = t;
    r.multiplicity     = hits;
    r.event_number     = ev;
    r.time_error_count = err;
    r.last             = lst;
    return r;
  endfunction

  function automatic result_t hit_word(hit_t h, logic [MULT_W-1:0] hits,
                                       logic [COUNT_W-1:0] ev, logic [COUNT_W-1:0] err,
                                       logic lst);
    result_t r;
    r.record_type      = REC_HIT;
    r.module_out       = h.module_req;
    r.channel_out      = h.channel;
    r.global_id        = h.gid;
    r.energy_out       = h.energy;
    r.local_time_out   = h.local_time;
    r.group_out        = h.time_group;
    r.full_time        = h.full;
    r.multiplicity     = hits;
    r.event_number     = ev;
    r.time_error_count = err;
    r.last             = lst;
    return r;
  endfunction

  // decision for the word at the head of the queue
  always_comb begin
    previous_time_next         = previous_time;
    have_previous_next         = have_previous;
    lowest_decreased_time_next = lowest_decreased_time;
    hits_in_event_next         = hits_in_event;
    event_open_next            = event_open;
    events_started_next        = events_started;
    error_total_next           = error_total;
    limit_reached_next         = limit_reached;
    halted_next                = halted;
    n_words                    = 2'd0;
    word0                      = '0;
    word1                      = '0;
    check_limit                = 1'b0;

    earlier = have_previous && (q_data.full < previous_time) && !cfg.skip_time_errors;
    joins   = have_previous && event_open && (q_data.full == previous_time);

    if (halted) begin
      n_words = 2'd0;
    end else if (q_data.kind == KIND_FLUSH) begin
      // end of file: close the open event, or halt if the event limit was reached
      if (limit_reached) begin
        halted_next = 1'b1;
      end else if (event_open) begin
        word0 = end_word(previous_time, hits_in_event, events_started, error_total, 1'b1);
        n_words            = 2'd1;
        event_open_next    = 1'b0;
        hits_in_event_next = '0;
      end
    end else if (earlier) begin
      // timestamp went backwards
      if (q_data.full < lowest_decreased_time) begin
        lowest_decreased_time_next = q_data.full;
        error_total_next           = error_total + 1'b1;
      end
      if (cfg.stop_on_time_error) begin
        halted_next = 1'b1;
      end
    end else if (joins) begin
      // same time joins the open event
      hits_in_event_next = (hits_in_event == MULT_MAX) ? hits_in_event
                                                       : hits_in_event + 1'b1;
      word0 = hit_word(q_data, hits_in_event_next, events_started, error_total, 1'b1);
      n_words     = 2'd1;
      check_limit = 1'b1;
    end else if (limit_reached) begin
      // limit hit: close out and stop
      halted_next     = 1'b1;
      event_open_next = 1'b0;
      if (event_open) begin
        word0 = end_word(previous_time, hits_in_event, events_started, error_total, 1'b1);
        n_words = 2'd1;
      end
    end else begin
      // new event, closing any open one first
      previous_time_next         = q_data.full;
      lowest_decreased_time_next = q_data.full;
      have_previous_next         = 1'b1;
      event_open_next            = 1'b1;
      hits_in_event_next         = MULT_W'(1);
      events_started_next        = events_started + 1'b1;
      check_limit                = 1'b1;
      if (event_open) begin
        word0 = end_word(previous_time, hits_in_event, events_started, error_total, 1'b0);
        word1 = hit_word(q_data, MULT_W'(1), events_started_next, error_total, 1'b1);
        n_words = 2'd2;
      end else begin
        word0 = hit_word(q_data, MULT_W'(1), events_started_next, error_total, 1'b1);
        n_words = 2'd1;
      end
    end

    if (check_limit && (cfg.event_limit != '0) && (events_started_next >= cfg.event_limit)) begin
      limit_reached_next = 1'b1;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign take     = q_valid && !pend_valid && ((n_words == 2'd0) || out_free);
  assign q_rd     = take;

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time         <= '0;
      have_previous         <= 1'b0;
      lowest_decreased_time <= '0;
      hits_in_event         <= '0;
      event_open            <= 1'b0;
      events_started        <= '0;
      error_total           <= '0;
      limit_reached         <= 1'b0;
      halted                <= 1'b0;
    end else if (take) begin
      previous_time         <= previous_time_next;
      have_previous         <= have_previous_next;
      lowest_decreased_time <= lowest_decreased_time_next;
      hits_in_event         <= hits_in_event_next;
      event_open            <= event_open_next;
      events_started        <= events_started_next;
      error_total           <= error_total_next;
      limit_reached         <= limit_reached_next;
      halted                <= halted_next;
    end
  end

  // output register and pending second word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (take && (n_words != 2'd0)) begin
        out_valid  <= 1'b1;
        pend_valid <= n_words == 2'd2;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        out_word <= pend_word;
      end else if (take && (n_words != 2'd0)) begin
        out_word  <= word0;
        pend_word <= word1;
      end
    end
  end

endmodule

// ----- sv/timestamp_event_builder_top.sv -----
// Timestamp event builder: groups detector hits into events by extended time.
// Input words (in_valid/in_stall) are hits or end-of-file flushes; result words
// (out_valid/out_stall) are hit records and event end records, with last set on
// the final word caused by an input. Registers are written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
// A word is taken whenever in_stall is low, one per cycle. Its first result
// passes through a queue slot and the output register; a word that closes an
// event and opens a new one gives two results. The output side runs at one
// result per cycle while out_stall is low. The front computes the extended
// time in the cycle of acceptance, a four-entry queue follows, and the back
// updates the event state and loads the output register.
// Synchronous reset clears all event state and configuration to zero.
// When out_stall is high the output word holds, the back takes no word that
// gives a result, the queue fills, and in_stall rises once four words wait.
// depends on teb_pkg, teb_front, teb_queue, teb_back
module timestamp_event_builder_top import teb_pkg::*; #(
  parameter int CHANNELS_PER_MODULE = CHANNELS_PER_MODULE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [MOD_W-1:0]    module_req,
  input  logic [CH_W-1:0]     channel,
  input  logic [ENERGY_W-1:0] energy,
  input  logic [LTIME_W-1:0]  local_time,
  input  logic [GROUP_W-1:0]  time_group,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [COUNT_W-1:0]  cfg_data,
  // result words
  output logic                out_valid,
  input  logic                out_stall,
  output logic                record_type,
  output logic [MOD_W-1:0]    module_out,
  output logic [CH_W-1:0]     channel_out,
  output logic [GID_W-1:0]    global_id,
  output logic [ENERGY_W-1:0] energy_out,
  output logic [LTIME_W-1:0]  local_time_out,
  output logic [GROUP_W-1:0]  group_out,
  output logic [FULL_W-1:0]   full_time,
  output logic [MULT_W-1:0]   multiplicity,
  output logic [COUNT_W-1:0]  event_number,
  output logic [COUNT_W-1:0]  time_error_count,
  output logic                last
);

  cfg_t    cfg;
  logic    q_full;
  logic    q_wr;
  hit_t    q_wr_data;
  logic    q_rd;
  logic    q_valid;
  hit_t    q_rd_data;
  result_t out_word;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_ENERGY_THRESHOLD:   cfg.energy_threshold   <= cfg_data[ENERGY_W-1:0];
        CFG_SKIP_TIME_ERRORS:   cfg.skip_time_errors   <= cfg_data[0];
        CFG_STOP_ON_TIME_ERROR: cfg.stop_on_time_error <= cfg_data[0];
        CFG_EVENT_LIMIT:        cfg.event_limit        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  teb_front #(
    .CHANNELS_PER_MODULE(CHANNELS_PER_MODULE)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .module_req(module_req),
    .channel   (channel),
    .energy    (energy),
    .local_time(local_time),
    .time_group(time_group),
    .cfg       (cfg),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_data    (q_wr_data)
  );

  teb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_valid(q_valid),
    .rd_data (q_rd_data)
  );

  teb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_data   (q_rd_data),
    .q_rd     (q_rd),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // result word onto the ports
  assign record_type      = out_word.record_type;
  assign module_out       = out_word.module_out;
  assign channel_out      = out_word.channel_out;
  assign global_id        = out_word.global_id;
  assign energy_out       = out_word.energy_out;
  assign local_time_out   = out_word.local_time_out;
  assign group_out        = out_word.group_out;
  assign full_time        = out_word.full_time;
  assign multiplicity     = out_word.multiplicity;
  assign event_number     = out_word.event_number;
  assign time_error_count = out_word.time_error_count;
  assign last             = out_word.last;

endmodule
